/* rtl/ialu_pkg.sv */
// Shared opcodes, constants and control types of the integer ALU.
package ialu_pkg;

    localparam int unsigned DATA_W    = 64;
    localparam int unsigned HALF_W    = 32;
    localparam int unsigned OP_W      = 6;
    localparam int unsigned DIV_STEPS = DATA_W;

    localparam logic [OP_W-1:0] OP_ADD  = 6'd14;
    localparam logic [OP_W-1:0] OP_SUB  = 6'd16;
    localparam logic [OP_W-1:0] OP_MUL  = 6'd18;
    localparam logic [OP_W-1:0] OP_UDIV = 6'd20;
    localparam logic [OP_W-1:0] OP_SDIV = 6'd21;
    localparam logic [OP_W-1:0] OP_UREM = 6'd23;
    localparam logic [OP_W-1:0] OP_SREM = 6'd24;
    localparam logic [OP_W-1:0] OP_SHL  = 6'd26;
    localparam logic [OP_W-1:0] OP_LSHR = 6'd27;
    localparam logic [OP_W-1:0] OP_ASHR = 6'd28;
    localparam logic [OP_W-1:0] OP_AND  = 6'd29;
    localparam logic [OP_W-1:0] OP_OR   = 6'd30;
    localparam logic [OP_W-1:0] OP_XOR  = 6'd31;

    localparam logic [DATA_W-1:0] MAXPOS_64 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [DATA_W-1:0] MAXPOS_32 = 64'h0000_0000_7FFF_FFFF;

    // control that travels with each beat down the divider chain
    typedef struct packed {
        logic is_div;
        logic want_rem;
        logic neg_q;
        logic neg_r;
        logic div_zero;
        logic wide;
        logic err;
    } ctl_t;

endpackage

/* rtl/integer_arith_alu.sv */
// Integer ALU top level: decode stage, divider cell chain and result stage.
//
// Usage: drive action, is_wide, operand_a and operand_b and raise start for
// one cycle per operation. busy is always low, so a new beat is taken on
// every cycle that start is high. Each beat gives exactly one result beat:
// done is high for one cycle with result and op_error valid in that cycle.
// The accepting edge loads the decode stage, then 64 division cells (one
// quotient bit each) and one result stage follow.
// Every operation, divide or not, runs down the same chain, so results leave
// in order and throughput is one operation per cycle.
// The receiver cannot stall; results must be taken when done is high.
// Reset (rst_n low, asynchronous) drops every beat in flight; no done follows
// for operations accepted before reset.
// In 32-bit mode the low operand halves are used and the result is
// sign-extended. A zero divisor gives the largest positive value of the width.
// An unknown opcode gives result zero with op_error set.
module integer_arith_alu
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ialu_pkg::OP_W-1:0]     action,
    input  logic                          is_wide,
    input  logic [ialu_pkg::DATA_W-1:0]   operand_a,
    input  logic [ialu_pkg::DATA_W-1:0]   operand_b,
    output logic                          done,
    output logic [ialu_pkg::DATA_W-1:0]   result,
    output logic                          op_error
);
    import ialu_pkg::*;

    logic              p_valid;
    ctl_t              p_ctl;
    logic              p_is_mul;
    logic [DATA_W-1:0] p_simple, p_p0, p_dividend, p_divisor;
    logic [HALF_W-1:0] p_p1, p_p2;
    logic [HALF_W-1:0] cross_sum;

    logic              c_valid [DIV_STEPS+1];
    ctl_t              c_ctl   [DIV_STEPS+1];
    logic [DATA_W-1:0] c_rem   [DIV_STEPS+1];
    logic [DATA_W-1:0] c_dq    [DIV_STEPS+1];
    logic [DATA_W-1:0] c_dvs   [DIV_STEPS+1];
    logic [DATA_W-1:0] c_res   [DIV_STEPS+1];

    ctl_t              f_ctl;
    logic [DATA_W-1:0] f_sel, f_div, f_val;
    logic              f_neg;

    logic              done_reg;
    logic              err_reg;
    logic              wide_reg;
    logic [DATA_W-1:0] result_reg;

    assign busy = 1'b0;

    ialu_prep u_prep
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (start && !busy),
        .action       (action),
        .is_wide      (is_wide),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .out_valid    (p_valid),
        .out_ctl      (p_ctl),
        .out_is_mul   (p_is_mul),
        .out_simple   (p_simple),
        .out_p0       (p_p0),
        .out_p1       (p_p1),
        .out_p2       (p_p2),
        .out_dividend (p_dividend),
        .out_divisor  (p_divisor)
    );

    // fold the cross products into the low product on the way into the chain
    assign cross_sum  = p_p1 + p_p2;
    assign c_valid[0] = p_valid;
    assign c_ctl[0]   = p_ctl;
    assign c_rem[0]   = '0;
    assign c_dq[0]    = p_dividend;
    assign c_dvs[0]   = p_divisor;
    assign c_res[0]   = p_is_mul ? (p_p0 + {cross_sum, {HALF_W{1'b0}}}) : p_simple;

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_cell
        ialu_div_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (c_valid[i]),
            .in_ctl    (c_ctl[i]),
            .in_rem    (c_rem[i]),
            .in_dq     (c_dq[i]),
            .in_dvs    (c_dvs[i]),
            .in_res    (c_res[i]),
            .out_valid (c_valid[i+1]),
            .out_ctl   (c_ctl[i+1]),
            .out_rem   (c_rem[i+1]),
            .out_dq    (c_dq[i+1]),
            .out_dvs   (c_dvs[i+1]),
            .out_res   (c_res[i+1])
        );
    end

    always_comb
    begin
        f_ctl = c_ctl[DIV_STEPS];
        f_sel = f_ctl.want_rem ? c_rem[DIV_STEPS] : c_dq[DIV_STEPS];
        f_neg = f_ctl.want_rem ? f_ctl.neg_r : f_ctl.neg_q;
        if (f_ctl.div_zero)
            f_div = f_ctl.wide ? MAXPOS_64 : MAXPOS_32;
        else
            f_div = f_neg ? (~f_sel + 1'b1) : f_sel;
        if (f_ctl.err)
            f_val = '0;
        else if (f_ctl.is_div)
            f_val = f_div;
        else
            f_val = c_res[DIV_STEPS];
        // narrow operations come back sign-extended
        if (!f_ctl.wide && !f_ctl.err)
            f_val = {{HALF_W{f_val[HALF_W-1]}}, f_val[HALF_W-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= c_valid[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= f_val;
        err_reg    <= f_ctl.err;
        wide_reg   <= f_ctl.wide;
    end

    assign done     = done_reg;
    assign result   = result_reg;
    assign op_error = err_reg;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && op_error |-> result == '0)
        else $error("unknown opcode with non-zero result");

    a_narrow_sext: assert property (@(posedge clk) disable iff (!rst_n)
        done && !wide_reg && !op_error |-> result[DATA_W-1:HALF_W] == {HALF_W{result[HALF_W-1]}})
        else $error("32-bit result not sign-extended");

    a_chain_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid[DIV_STEPS] |=> done)
        else $error("beat leaving the chain lost");

    a_done_from_chain: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(c_valid[DIV_STEPS]))
        else $error("result beat without a chain beat");

endmodule

/* rtl/ialu_prep.sv */
// Operand decode stage: views, simple results, partial products, divider set-up.
module ialu_prep
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [ialu_pkg::OP_W-1:0]     action,
    input  logic                          is_wide,
    input  logic [ialu_pkg::DATA_W-1:0]   operand_a,
    input  logic [ialu_pkg::DATA_W-1:0]   operand_b,
    output logic                          out_valid,
    output ialu_pkg::ctl_t                out_ctl,
    output logic                          out_is_mul,
    output logic [ialu_pkg::DATA_W-1:0]   out_simple,
    output logic [ialu_pkg::DATA_W-1:0]   out_p0,
    output logic [ialu_pkg::HALF_W-1:0]   out_p1,
    output logic [ialu_pkg::HALF_W-1:0]   out_p2,
    output logic [ialu_pkg::DATA_W-1:0]   out_dividend,
    output logic [ialu_pkg::DATA_W-1:0]   out_divisor
);
    import ialu_pkg::*;

    logic [DATA_W-1:0] sa, sb, ua, ub;
    logic [5:0]        sh;
    logic [DATA_W-1:0] simple;
    logic [DATA_W-1:0] m1, m2;
    logic              signed_div;
    ctl_t              ctl;
    logic              is_mul;

    logic              valid_reg;
    ctl_t              ctl_reg;
    logic              is_mul_reg;
    logic [DATA_W-1:0] simple_reg, p0_reg, dividend_reg, divisor_reg;
    logic [HALF_W-1:0] p1_reg, p2_reg;

    always_comb
    begin
        sa = is_wide ? operand_a : {{HALF_W{operand_a[HALF_W-1]}}, operand_a[HALF_W-1:0]};
        sb = is_wide ? operand_b : {{HALF_W{operand_b[HALF_W-1]}}, operand_b[HALF_W-1:0]};
        ua = is_wide ? operand_a : {{HALF_W{1'b0}}, operand_a[HALF_W-1:0]};
        ub = is_wide ? operand_b : {{HALF_W{1'b0}}, operand_b[HALF_W-1:0]};
        sh = is_wide ? operand_b[5:0] : {1'b0, operand_b[4:0]};
        m1 = {{HALF_W{1'b0}}, operand_a[DATA_W-1:HALF_W]} * {{HALF_W{1'b0}}, operand_b[HALF_W-1:0]};
        m2 = {{HALF_W{1'b0}}, operand_a[HALF_W-1:0]} * {{HALF_W{1'b0}}, operand_b[DATA_W-1:HALF_W]};

        simple     = '0;
        is_mul     = 1'b0;
        signed_div = 1'b0;
        ctl        = '0;
        ctl.wide   = is_wide;
        unique case (action)
            OP_ADD:  simple = operand_a + operand_b;
            OP_SUB:  simple = operand_a - operand_b;
            OP_MUL:  is_mul = 1'b1;
            OP_UDIV: ctl.is_div = 1'b1;
            OP_UREM:
            begin
                ctl.is_div   = 1'b1;
                ctl.want_rem = 1'b1;
            end
            OP_SDIV:
            begin
                ctl.is_div = 1'b1;
                signed_div = 1'b1;
            end
            OP_SREM:
            begin
                ctl.is_div   = 1'b1;
                ctl.want_rem = 1'b1;
                signed_div   = 1'b1;
            end
            OP_SHL:  simple = operand_a << sh;
            OP_LSHR: simple = ua >> sh;
            OP_ASHR: simple = $unsigned($signed(sa) >>> sh);
            OP_AND:  simple = operand_a & operand_b;
            OP_OR:   simple = operand_a | operand_b;
            OP_XOR:  simple = operand_a ^ operand_b;
            default: ctl.err = 1'b1;
        endcase
        ctl.neg_q    = signed_div && (sa[DATA_W-1] ^ sb[DATA_W-1]);
        ctl.neg_r    = signed_div && sa[DATA_W-1];
        ctl.div_zero = (ub == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        ctl_reg      <= ctl;
        is_mul_reg   <= is_mul;
        simple_reg   <= simple;
        p0_reg       <= {{HALF_W{1'b0}}, operand_a[HALF_W-1:0]}
                        * {{HALF_W{1'b0}}, operand_b[HALF_W-1:0]};
        p1_reg       <= m1[HALF_W-1:0];
        p2_reg       <= m2[HALF_W-1:0];
        dividend_reg <= (signed_div && sa[DATA_W-1]) ? (~sa + 1'b1) : (signed_div ? sa : ua);
        divisor_reg  <= (signed_div && sb[DATA_W-1]) ? (~sb + 1'b1) : (signed_div ? sb : ub);
    end

    assign out_valid    = valid_reg;
    assign out_ctl      = ctl_reg;
    assign out_is_mul   = is_mul_reg;
    assign out_simple   = simple_reg;
    assign out_p0       = p0_reg;
    assign out_p1       = p1_reg;
    assign out_p2       = p2_reg;
    assign out_dividend = dividend_reg;
    assign out_divisor  = divisor_reg;

endmodule

/* rtl/ialu_div_cell.sv */
// One restoring-division cell: retires one quotient bit and passes the beat on.
module ialu_div_cell
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  ialu_pkg::ctl_t              in_ctl,
    input  logic [ialu_pkg::DATA_W-1:0] in_rem,
    input  logic [ialu_pkg::DATA_W-1:0] in_dq,
    input  logic [ialu_pkg::DATA_W-1:0] in_dvs,
    input  logic [ialu_pkg::DATA_W-1:0] in_res,
    output logic                        out_valid,
    output ialu_pkg::ctl_t              out_ctl,
    output logic [ialu_pkg::DATA_W-1:0] out_rem,
    output logic [ialu_pkg::DATA_W-1:0] out_dq,
    output logic [ialu_pkg::DATA_W-1:0] out_dvs,
    output logic [ialu_pkg::DATA_W-1:0] out_res
);
    import ialu_pkg::*;

    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;
    logic              fits;
    logic              valid_reg;
    ctl_t              ctl_reg;
    logic [DATA_W-1:0] rem_reg, dq_reg, dvs_reg, res_reg;

    // shift in the next dividend bit and try the subtract
    always_comb
    begin
        trial = {in_rem, in_dq[DATA_W-1]};
        diff  = trial - {1'b0, in_dvs};
        fits  = (trial >= {1'b0, in_dvs});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        ctl_reg <= in_ctl;
        rem_reg <= fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        dq_reg  <= {in_dq[DATA_W-2:0], fits};
        dvs_reg <= in_dvs;
        res_reg <= in_res;
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_rem   = rem_reg;
    assign out_dq    = dq_reg;
    assign out_dvs   = dvs_reg;
    assign out_res   = res_reg;

endmodule

/* dv/integer_arith_alu_tb.sv */
// Self-checking testbench for the 32/64-bit integer ALU.
`timescale 1ns / 1ps

module integer_arith_alu_tb;
    import ialu_pkg::*;

    localparam int unsigned LATENCY   = 66;
    localparam int unsigned N_RANDOM  = 1450;
    localparam int unsigned MAX_CYCLES = 200000;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              wide;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic              known;
        logic [DATA_W-1:0] res;
        logic              err;
    } alu_row_t;

    typedef struct packed {
        logic [DATA_W-1:0] res;
        logic              err;
    } alu_out_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [OP_W-1:0]   action;
    logic              is_wide;
    logic [DATA_W-1:0] operand_a;
    logic [DATA_W-1:0] operand_b;
    logic              done;
    logic [DATA_W-1:0] result;
    logic              op_error;

    alu_out_t    pending_results[$];
    alu_row_t    directed_rows[$];
    int unsigned n_errors;
    int unsigned n_results;
    int unsigned n_beats;
    int unsigned cycle_count;

    integer_arith_alu dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .action    (action),
        .is_wide   (is_wide),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .done      (done),
        .result    (result),
        .op_error  (op_error)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic logic [DATA_W-1:0] sign_ext32(input logic [DATA_W-1:0] x);
        return {{HALF_W{x[HALF_W-1]}}, x[HALF_W-1:0]};
    endfunction

    // Compute the expected ALU output for one operation.
    function automatic alu_out_t alu_predict(input logic [OP_W-1:0] op, input logic wide,
                                            input logic [DATA_W-1:0] a,
                                            input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] sa, sb, ua, ub, maxpos, r, ma, mb, q, rm;
        int unsigned       sh;
        logic              err;
        alu_out_t          o;
        sa     = wide ? a : sign_ext32(a);
        sb     = wide ? b : sign_ext32(b);
        ua     = wide ? a : {32'b0, a[31:0]};
        ub     = wide ? b : {32'b0, b[31:0]};
        maxpos = wide ? MAXPOS_64 : MAXPOS_32;
        sh     = wide ? 32'(b[5:0]) : 32'(b[4:0]);
        err    = 1'b0;
        r      = '0;
        ma     = sa[63] ? -sa : sa;
        mb     = sb[63] ? -sb : sb;
        q      = (mb == 0) ? '0 : ma / mb;
        rm     = (mb == 0) ? '0 : ma % mb;
        case (op)
            OP_ADD:  r = a + b;
            OP_SUB:  r = a - b;
            OP_MUL:  r = a * b;
            OP_UDIV: r = (ub == 0) ? maxpos : ua / ub;
            OP_UREM: r = (ub == 0) ? maxpos : ua % ub;
            OP_SDIV: r = (sb == 0) ? maxpos : ((sa[63] != sb[63]) ? -q : q);
            OP_SREM: r = (sb == 0) ? maxpos : (sa[63] ? -rm : rm);
            OP_SHL:  r = a << sh;
            OP_LSHR: r = ua >> sh;
            OP_ASHR: r = $signed(sa) >>> sh;
            OP_AND:  r = a & b;
            OP_OR:   r = a | b;
            OP_XOR:  r = a ^ b;
            default:
            begin
                err = 1'b1;
                r   = '0;
            end
        endcase
        if (!wide && !err)
            r = sign_ext32(r);
        o.res = r;
        o.err = err;
        return o;
    endfunction

    function automatic alu_row_t mk_row(input logic [OP_W-1:0] op, input logic wide,
                                        input logic [DATA_W-1:0] a,
                                        input logic [DATA_W-1:0] b,
                                        input logic known,
                                        input logic [DATA_W-1:0] res,
                                        input logic err);
        alu_row_t t;
        t.op = op; t.wide = wide; t.a = a; t.b = b;
        t.known = known; t.res = res; t.err = err;
        return t;
    endfunction

    // Issue one beat, sometimes after a random idle gap; hold start high across back-to-back beats.
    task automatic send_beat(input logic [OP_W-1:0] op, input logic wide,
                             input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
                             input alu_out_t want);
        int unsigned gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        action    <= op;
        is_wide   <= wide;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(want);
        n_beats++;
    endtask

    function automatic logic [DATA_W-1:0] rand_operand();
        logic [DATA_W-1:0] v;
        v = {$urandom(), $urandom()};
        case ($urandom_range(0, 7))
            0: v = 64'h8000_0000_0000_0000;
            1: v = '1;
            2: v = {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0, 32'h8000_0000};
            3: v = $urandom_range(0, 9);
            4: v = -$urandom_range(0, 9);
            5: v = {32'h0, $urandom()};
            default: ;
        endcase
        return v;
    endfunction

    // Check each result beat against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat result=%h op_error=%b",
                         $time, result, op_error);
                n_errors++;
            end
            else
            begin
                alu_out_t exp_o;
                exp_o = pending_results.pop_front();
                n_results++;
                if (result !== exp_o.res)
                begin
                    $display("%0t: result mismatch: expected %h, actual %h",
                             $time, exp_o.res, result);
                    n_errors++;
                end
                if (op_error !== exp_o.err)
                begin
                    $display("%0t: op_error mismatch: expected %b, actual %b",
                             $time, exp_o.err, op_error);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        alu_row_t    row;
        alu_out_t    want;
        logic [OP_W-1:0] op;
        logic [OP_W-1:0] op_list[13];

        n_errors    = 0;
        n_results   = 0;
        n_beats     = 0;
        cycle_count = 0;
        rst_n     = 1'b0;
        start     = 1'b0;
        action    = '0;
        is_wide   = 1'b0;
        operand_a = '0;
        operand_b = '0;
        op_list = '{OP_ADD, OP_SUB, OP_MUL, OP_UDIV, OP_SDIV, OP_UREM, OP_SREM,
                    OP_SHL, OP_LSHR, OP_ASHR, OP_AND, OP_OR, OP_XOR};

        // Directed table: extremes, zero divisors, min / -1, shift wrap, bad opcodes.
        directed_rows.push_back(mk_row(OP_ADD, 1, 64'h7FFF_FFFF_FFFF_FFFF, 64'd1, 1,
                                       64'h8000_0000_0000_0000, 0));
        directed_rows.push_back(mk_row(OP_ADD, 0, 64'h0000_0000_7FFF_FFFF, 64'd1, 1,
                                       64'hFFFF_FFFF_8000_0000, 0));
        directed_rows.push_back(mk_row(OP_SUB, 1, 64'd0, 64'd1, 1, '1, 0));
        directed_rows.push_back(mk_row(OP_MUL, 1, '1, '1, 1, 64'd1, 0));
        directed_rows.push_back(mk_row(OP_UDIV, 1, '1, 64'd0, 1, MAXPOS_64, 0));
        directed_rows.push_back(mk_row(OP_UDIV, 0, '1, 64'hFFFF_FFFF_0000_0000, 1,
                                       MAXPOS_32, 0));
        directed_rows.push_back(mk_row(OP_SDIV, 1, 64'd5, 64'd0, 1, MAXPOS_64, 0));
        directed_rows.push_back(mk_row(OP_UREM, 0, 64'd5, 64'd0, 1, MAXPOS_32, 0));
        directed_rows.push_back(mk_row(OP_SREM, 1, 64'd5, 64'd0, 1, MAXPOS_64, 0));
        directed_rows.push_back(mk_row(OP_SDIV, 1, 64'h8000_0000_0000_0000, '1, 1,
                                       64'h8000_0000_0000_0000, 0));
        directed_rows.push_back(mk_row(OP_SREM, 1, 64'h8000_0000_0000_0000, '1, 1,
                                       64'd0, 0));
        directed_rows.push_back(mk_row(OP_SDIV, 0, 64'h0000_0000_8000_0000, '1, 1,
                                       64'hFFFF_FFFF_8000_0000, 0));
        directed_rows.push_back(mk_row(OP_SREM, 0, 64'h0000_0000_8000_0000, '1, 1,
                                       64'd0, 0));
        directed_rows.push_back(mk_row(OP_SDIV, 1, -64'sd7, 64'd2, 0, '0, 0));
        directed_rows.push_back(mk_row(OP_SREM, 0, -64'sd7, 64'd2, 0, '0, 0));
        directed_rows.push_back(mk_row(OP_SHL, 1, 64'd1, 64'd64, 1, 64'd1, 0));
        directed_rows.push_back(mk_row(OP_SHL, 0, 64'd1, 64'd31, 1,
                                       64'hFFFF_FFFF_8000_0000, 0));
        directed_rows.push_back(mk_row(OP_LSHR, 0, '1, 64'd33, 0, '0, 0));
        directed_rows.push_back(mk_row(OP_ASHR, 1, 64'h8000_0000_0000_0000, 64'd63, 1,
                                       '1, 0));
        directed_rows.push_back(mk_row(OP_ASHR, 0, 64'h0000_0000_8000_0000, 64'd36, 0,
                                       '0, 0));
        directed_rows.push_back(mk_row(OP_AND, 1, '1, 64'h5555_5555_5555_5555, 0, '0, 0));
        directed_rows.push_back(mk_row(OP_OR, 0, 64'h8000_0000, 64'd0, 0, '0, 0));
        directed_rows.push_back(mk_row(OP_XOR, 1, '1, '1, 1, 64'd0, 0));
        directed_rows.push_back(mk_row(6'd0, 1, '1, '1, 1, 64'd0, 1));
        directed_rows.push_back(mk_row(6'd63, 0, '1, '1, 1, 64'd0, 1));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.known)
            begin
                want.res = row.res;
                want.err = row.err;
            end
            else
                want = alu_predict(row.op, row.wide, row.a, row.b);
            send_beat(row.op, row.wide, row.a, row.b, want);
        end

        for (int unsigned n = 0; n < N_RANDOM; n++)
        begin
            logic              w;
            logic [DATA_W-1:0] a;
            logic [DATA_W-1:0] b;
            // Mostly valid opcodes; every opcode value turns up now and then.
            if ($urandom_range(0, 9) == 0)
                op = $urandom_range(0, 63);
            else
                op = op_list[$urandom_range(0, 12)];
            w = $urandom_range(0, 1);
            a = rand_operand();
            b = rand_operand();
            send_beat(op, w, a, b, alu_predict(op, w, a, b));
        end
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);

        $display("Drove %0d operations over all opcodes, both widths and corner operands;",
                 n_beats);
        $display("checked %0d result beats, %0d mismatches.", n_results, n_errors);
        if (n_errors == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
